>>> src/gfems_pkg.sv
// ---------------------------------------------------------------------------
// gfems_pkg : shared types and constants
// Item layouts, controller state and command encoding for the GF(2^m)
// extended min-sum two-input combine.
// ---------------------------------------------------------------------------
`default_nettype none

package gfems_pkg;

  localparam int unsigned Lanes     = 4;
  localparam int unsigned StoreRows = 64;            // 256 symbols / 4 lanes
  localparam int unsigned RowW      = 6;
  localparam int unsigned IdxW      = 8;             // GF(256) symbol index
  localparam int unsigned NmLarge   = 13;
  localparam int unsigned NmSmall   = 7;
  localparam int unsigned NmW       = 4;             // indexes 0..NmLarge-1
  localparam int unsigned LoadCntW  = 7;

  typedef logic signed [15:0] llr_t;

  typedef struct packed {
    llr_t x_value_0;
    llr_t x_value_1;
    llr_t x_value_2;
    llr_t x_value_3;
    llr_t y_value_0;
    llr_t y_value_1;
    llr_t y_value_2;
    llr_t y_value_3;
  } in_item_t;

  typedef struct packed {
    llr_t z_value_0;
    llr_t z_value_1;
    llr_t z_value_2;
    llr_t z_value_3;
    logic last_group;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SORT,
    ST_SORT_END,
    ST_P1,
    ST_P1_END,
    ST_P2,
    ST_P2_END,
    ST_P3_RD,
    ST_P3_WR,
    ST_EMIT_RD,
    ST_EMIT_WAIT
  } state_e;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_SORT,
    OP_P1,
    OP_P2,
    OP_P3,
    OP_EMIT
  } op_e;

  typedef struct packed {
    op_e             op;
    logic            order_sel;
    logic            list_clr;
    logic [IdxW-1:0] idx;        // load row, pass index or emit row
    logic [NmW-1:0]  pi;
    logic [NmW-1:0]  pj;
    logic            last;
  } cmd_t;

  typedef struct packed {
    logic out_valid;
    logic out_taken;
  } status_t;

endpackage

`default_nettype wire

>>> src/gf_ems_two_input_combine.sv
// ---------------------------------------------------------------------------
// gf_ems_two_input_combine : GF(2^m) extended min-sum two-input combine
// Loads x and y four symbols a beat, picks the best candidates of each,
// builds z by XOR-indexed max-combine and returns it four symbols a beat.
//
//   channel | signals                         | direction
//   --------+---------------------------------+----------
//   in      | in_valid_i, in_stall_o, in_data_i   | x/y in
//   out     | out_valid_o, out_stall_i, out_data_o | z out
//   cfg     | cfg_we_i, cfg_wdata_i           | order select
//
// Load takes one beat a cycle while in_valid_i is high (16 or 64 beats). The
// last beat starts the combine: selection sweep and two configuration passes
// (one store row read a cycle), the NM*NM pair combine, then the result
// beats, each held until it is taken.
// Reset clears control only; order_select resets to 1 (GF(256)).
// in_stall_o is high after the last load beat until the last z beat is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module gf_ems_two_input_combine (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic                  cfg_wdata_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire gfems_pkg::in_item_t   in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output gfems_pkg::out_item_t       out_data_o
);

  gfems_pkg::cmd_t    cmd;
  gfems_pkg::status_t status;

  gfems_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  gfems_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .status_o    (status)
  );

endmodule

`default_nettype wire

>>> src/gfems_topn.sv
// ---------------------------------------------------------------------------
// gfems_topn : running top-N list
// Sorted insertion list, descending; an equal value never displaces an
// entry already held, so earlier (lower) indices win ties.
// ---------------------------------------------------------------------------
`default_nettype none

module gfems_topn (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    clr_i,
  input  wire logic                                    ins_i,
  input  wire gfems_pkg::llr_t                         value_i,
  input  wire logic [gfems_pkg::IdxW-1:0]              index_i,
  output gfems_pkg::llr_t [gfems_pkg::NmLarge-1:0]     vals_o,
  output logic [gfems_pkg::NmLarge-1:0][gfems_pkg::IdxW-1:0] idxs_o
);

  localparam int unsigned N = gfems_pkg::NmLarge;

  gfems_pkg::llr_t [N-1:0]               val_q, val_d;
  logic [N-1:0][gfems_pkg::IdxW-1:0]     idx_q, idx_d;
  logic [N-1:0]                          vld_q, vld_d;
  logic [N-1:0]                          ge;

  always_comb begin
    for (int r = 0; r < N; r++) begin
      ge[r] = vld_q[r] && (val_q[r] >= value_i);
    end
    val_d[0] = ge[0] ? val_q[0] : value_i;
    idx_d[0] = ge[0] ? idx_q[0] : index_i;
    vld_d[0] = 1'b1;
    for (int r = 1; r < N; r++) begin
      if (ge[r]) begin
        val_d[r] = val_q[r];
        idx_d[r] = idx_q[r];
        vld_d[r] = 1'b1;
      end else if (ge[r-1]) begin
        val_d[r] = value_i;
        idx_d[r] = index_i;
        vld_d[r] = 1'b1;
      end else begin
        val_d[r] = val_q[r-1];
        idx_d[r] = idx_q[r-1];
        vld_d[r] = vld_q[r-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (clr_i) begin
      vld_q <= '0;
    end else if (ins_i) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ins_i) begin
      val_q <= val_d;
      idx_q <= idx_d;
    end
  end

  assign vals_o = val_q;
  assign idxs_o = idx_q;

endmodule

`default_nettype wire

>>> src/gfems_dpath.sv
// ---------------------------------------------------------------------------
// gfems_dpath : stores, top-N lists and combine arithmetic
// Row-wide x/y/z stores (4 lanes a row), a one-stage read pipeline that
// performs each commanded step, and the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module gfems_dpath (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire gfems_pkg::cmd_t      cmd_i,
  input  wire gfems_pkg::in_item_t  in_data_i,
  input  wire logic                 out_stall_i,
  output logic                      out_valid_o,
  output gfems_pkg::out_item_t      out_data_o,
  output gfems_pkg::status_t        status_o
);

  localparam int unsigned N = gfems_pkg::NmLarge;
  localparam gfems_pkg::llr_t LowClamp = -16'sd32766;

  function automatic gfems_pkg::llr_t clamp_low(gfems_pkg::llr_t v);
    clamp_low = (v < LowClamp) ? LowClamp : v;
  endfunction

  gfems_pkg::llr_t [gfems_pkg::Lanes-1:0] x_mem [gfems_pkg::StoreRows];
  gfems_pkg::llr_t [gfems_pkg::Lanes-1:0] y_mem [gfems_pkg::StoreRows];
  gfems_pkg::llr_t [gfems_pkg::Lanes-1:0] z_mem [gfems_pkg::StoreRows];
  gfems_pkg::llr_t [gfems_pkg::Lanes-1:0] x_rd_q, y_rd_q, z_rd_q;
  gfems_pkg::llr_t [gfems_pkg::Lanes-1:0] in_x, in_y;

  gfems_pkg::llr_t [N-1:0]               xbv, ybv;
  logic [N-1:0][gfems_pkg::IdxW-1:0]     xbi, ybi;

  gfems_pkg::op_e                op_q;
  logic [gfems_pkg::IdxW-1:0]    idx_q, k_q, k_d;
  gfems_pkg::llr_t               sum_q;
  logic                          last_q;

  logic                          load_en;
  logic [gfems_pkg::RowW-1:0]    z_raddr;
  gfems_pkg::llr_t               xl, yl, zl, cand;
  logic                          z_we;

  logic                          out_valid_q;
  gfems_pkg::out_item_t          out_q;

  assign in_x = {in_data_i.x_value_3, in_data_i.x_value_2,
                 in_data_i.x_value_1, in_data_i.x_value_0};
  assign in_y = {in_data_i.y_value_3, in_data_i.y_value_2,
                 in_data_i.y_value_1, in_data_i.y_value_0};

  // in the small order only the first 16 rows belong to the vector
  assign load_en = cmd_i.order_sel || (cmd_i.idx[6:4] == 3'd0);

  always_comb begin
    case (cmd_i.op)
      gfems_pkg::OP_P1: k_d = xbi[0] ^ cmd_i.idx;
      gfems_pkg::OP_P2: k_d = ybi[0] ^ cmd_i.idx;
      gfems_pkg::OP_P3: k_d = xbi[cmd_i.pi] ^ ybi[cmd_i.pj];
      default:          k_d = cmd_i.idx;
    endcase
    z_raddr = (cmd_i.op == gfems_pkg::OP_EMIT) ? cmd_i.idx[gfems_pkg::RowW-1:0]
                                               : k_d[gfems_pkg::IdxW-1:2];
  end

  // second stage: read data is back
  assign xl = x_rd_q[idx_q[1:0]];
  assign yl = y_rd_q[idx_q[1:0]];
  assign zl = z_rd_q[k_q[1:0]];

  always_comb begin
    case (op_q)
      gfems_pkg::OP_P1: cand = xbv[0] + yl;
      gfems_pkg::OP_P2: cand = ybv[0] + xl;
      default:          cand = sum_q;
    endcase
    z_we = (op_q == gfems_pkg::OP_P1) ||
           (((op_q == gfems_pkg::OP_P2) || (op_q == gfems_pkg::OP_P3)) && (cand > zl));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == gfems_pkg::OP_LOAD && load_en) begin
      for (int l = 0; l < gfems_pkg::Lanes; l++) begin
        x_mem[cmd_i.idx[gfems_pkg::RowW-1:0]][l] <= clamp_low(in_x[l]);
        y_mem[cmd_i.idx[gfems_pkg::RowW-1:0]][l] <= clamp_low(in_y[l]);
      end
    end
    x_rd_q <= x_mem[cmd_i.idx[gfems_pkg::IdxW-1:2]];
    y_rd_q <= y_mem[cmd_i.idx[gfems_pkg::IdxW-1:2]];
  end

  always_ff @(posedge clk_i) begin
    if (z_we) begin
      z_mem[k_q[gfems_pkg::IdxW-1:2]][k_q[1:0]] <= cand;
    end
    z_rd_q <= z_mem[z_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= gfems_pkg::OP_NOP;
    end else begin
      op_q <= cmd_i.op;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= cmd_i.idx;
    k_q    <= k_d;
    sum_q  <= xbv[cmd_i.pi] + ybv[cmd_i.pj];
    last_q <= cmd_i.last;
  end

  gfems_topn u_x_best (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (cmd_i.list_clr),
    .ins_i   (op_q == gfems_pkg::OP_SORT),
    .value_i (xl),
    .index_i (idx_q),
    .vals_o  (xbv),
    .idxs_o  (xbi)
  );

  gfems_topn u_y_best (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (cmd_i.list_clr),
    .ins_i   (op_q == gfems_pkg::OP_SORT),
    .value_i (yl),
    .index_i (idx_q),
    .vals_o  (ybv),
    .idxs_o  (ybi)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (op_q == gfems_pkg::OP_EMIT) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_q == gfems_pkg::OP_EMIT) begin
      out_q.z_value_0  <= z_rd_q[0];
      out_q.z_value_1  <= z_rd_q[1];
      out_q.z_value_2  <= z_rd_q[2];
      out_q.z_value_3  <= z_rd_q[3];
      out_q.last_group <= last_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_data_o          = out_q;
  assign status_o.out_valid  = out_valid_q;
  assign status_o.out_taken  = out_valid_q && !out_stall_i;

endmodule

`default_nettype wire

>>> src/gfems_ctrl.sv
// ---------------------------------------------------------------------------
// gfems_ctrl : sequencing state machine
// Counts the load, walks the selection sweep, the two configuration passes,
// the pair combine and the result emission; holds the order register.
// ---------------------------------------------------------------------------
`default_nettype none

module gfems_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire gfems_pkg::status_t  status_i,
  output gfems_pkg::cmd_t          cmd_o
);

  gfems_pkg::state_e                state_q, state_d;
  logic [gfems_pkg::LoadCntW-1:0]   load_cnt_q, load_cnt_d;
  logic [gfems_pkg::IdxW-1:0]       cnt_q, cnt_d;
  logic [gfems_pkg::NmW-1:0]        pi_q, pi_d, pj_q, pj_d;
  logic [gfems_pkg::RowW-1:0]       emit_q, emit_d;
  logic                             order_sel_q;

  logic                             in_acc;
  logic [gfems_pkg::IdxW-1:0]       order_last;
  logic [gfems_pkg::LoadCntW-1:0]   items_last;
  logic [gfems_pkg::NmW-1:0]        nm_last;
  logic                             load_done;

  assign order_last = order_sel_q ? 8'd255 : 8'd63;
  assign items_last = order_sel_q ? 7'd63 : 7'd15;
  assign nm_last    = order_sel_q ? gfems_pkg::NmW'(gfems_pkg::NmLarge - 1)
                                  : gfems_pkg::NmW'(gfems_pkg::NmSmall - 1);
  assign in_acc     = in_valid_i && (state_q == gfems_pkg::ST_LOAD);
  // a count already past the item total (order lowered mid-vector) also ends it
  assign load_done  = load_cnt_q >= items_last;

  always_comb begin
    state_d    = state_q;
    load_cnt_d = load_cnt_q;
    cnt_d      = cnt_q;
    pi_d       = pi_q;
    pj_d       = pj_q;
    emit_d     = emit_q;
    unique case (state_q)
      gfems_pkg::ST_LOAD: begin
        if (in_acc) begin
          if (load_done) begin
            load_cnt_d = '0;
            cnt_d      = '0;
            state_d    = gfems_pkg::ST_SORT;
          end else begin
            load_cnt_d = load_cnt_q + 1'b1;
          end
        end
      end
      gfems_pkg::ST_SORT, gfems_pkg::ST_P1, gfems_pkg::ST_P2: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == order_last) begin
          cnt_d = '0;
          unique case (state_q)
            gfems_pkg::ST_SORT: state_d = gfems_pkg::ST_SORT_END;
            gfems_pkg::ST_P1:   state_d = gfems_pkg::ST_P1_END;
            default:            state_d = gfems_pkg::ST_P2_END;
          endcase
        end
      end
      gfems_pkg::ST_SORT_END: state_d = gfems_pkg::ST_P1;
      gfems_pkg::ST_P1_END:   state_d = gfems_pkg::ST_P2;
      gfems_pkg::ST_P2_END: begin
        pi_d    = '0;
        pj_d    = '0;
        state_d = gfems_pkg::ST_P3_RD;
      end
      gfems_pkg::ST_P3_RD: state_d = gfems_pkg::ST_P3_WR;
      gfems_pkg::ST_P3_WR: begin
        state_d = gfems_pkg::ST_P3_RD;
        if (pj_q == nm_last) begin
          pj_d = '0;
          if (pi_q == nm_last) begin
            emit_d  = '0;
            state_d = gfems_pkg::ST_EMIT_RD;
          end else begin
            pi_d = pi_q + 1'b1;
          end
        end else begin
          pj_d = pj_q + 1'b1;
        end
      end
      gfems_pkg::ST_EMIT_RD: state_d = gfems_pkg::ST_EMIT_WAIT;
      gfems_pkg::ST_EMIT_WAIT: begin
        if (status_i.out_taken) begin
          if (emit_q == items_last[gfems_pkg::RowW-1:0]) begin
            state_d = gfems_pkg::ST_LOAD;
          end else begin
            emit_d  = emit_q + 1'b1;
            state_d = gfems_pkg::ST_EMIT_RD;
          end
        end
      end
      default: state_d = gfems_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.op        = gfems_pkg::OP_NOP;
    cmd_o.order_sel = order_sel_q;
    cmd_o.pi        = pi_q;
    cmd_o.pj        = pj_q;
    in_stall_o      = (state_q != gfems_pkg::ST_LOAD);
    unique case (state_q)
      gfems_pkg::ST_LOAD: begin
        cmd_o.idx      = {1'b0, load_cnt_q};
        cmd_o.op       = in_acc ? gfems_pkg::OP_LOAD : gfems_pkg::OP_NOP;
        cmd_o.list_clr = in_acc && load_done;
      end
      gfems_pkg::ST_SORT: begin
        cmd_o.op  = gfems_pkg::OP_SORT;
        cmd_o.idx = cnt_q;
      end
      gfems_pkg::ST_P1: begin
        cmd_o.op  = gfems_pkg::OP_P1;
        cmd_o.idx = cnt_q;
      end
      gfems_pkg::ST_P2: begin
        cmd_o.op  = gfems_pkg::OP_P2;
        cmd_o.idx = cnt_q;
      end
      gfems_pkg::ST_P3_RD: cmd_o.op = gfems_pkg::OP_P3;
      gfems_pkg::ST_EMIT_RD: begin
        cmd_o.op   = gfems_pkg::OP_EMIT;
        cmd_o.idx  = {2'b00, emit_q};
        cmd_o.last = (emit_q == items_last[gfems_pkg::RowW-1:0]);
      end
      default: cmd_o.op = gfems_pkg::OP_NOP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gfems_pkg::ST_LOAD;
      load_cnt_q  <= '0;
      cnt_q       <= '0;
      pi_q        <= '0;
      pj_q        <= '0;
      emit_q      <= '0;
      order_sel_q <= 1'b1;
    end else begin
      state_q    <= state_d;
      load_cnt_q <= load_cnt_d;
      cnt_q      <= cnt_d;
      pi_q       <= pi_d;
      pj_q       <= pj_d;
      emit_q     <= emit_d;
      if (cfg_we_i) begin
        order_sel_q <= cfg_wdata_i;
      end
    end
  end

endmodule

`default_nettype wire

>>> verif/gf_ems_two_input_combine_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// gf_ems_two_input_combine_checker : z vector predictor and comparator
// Watches the in and out channels, mirrors the x/y stores and order select,
// computes the expected z beats when a vector completes and compares each
// accepted z beat with the oldest expected one.
// ---------------------------------------------------------------------------
`default_nettype none

module gf_ems_two_input_combine_checker (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic                 cfg_wdata_i,
  input  wire logic                 in_valid_i,
  input  wire logic                 in_stall_o,
  input  wire gfems_pkg::in_item_t  in_data_i,
  input  wire logic                 out_valid_o,
  input  wire logic                 out_stall_i,
  input  wire gfems_pkg::out_item_t out_data_o,
  output int                        fail_count_o,
  output int                        pending_o
);

  localparam int SmallOrder = 64;
  localparam int LargeOrder = 256;
  localparam int NLanes     = int'(gfems_pkg::Lanes);
  localparam logic signed [15:0] LowClamp = -16'sd32766;

  gfems_pkg::llr_t      x_mem [256];
  gfems_pkg::llr_t      y_mem [256];
  logic                 order_sel;
  int                   beats_loaded;
  gfems_pkg::out_item_t z_queue [$];

  assign pending_o = z_queue.size();

  function automatic gfems_pkg::llr_t clamp_llr(gfems_pkg::llr_t v);
    return (v < LowClamp) ? LowClamp : v;
  endfunction

  // top-n, descending, lowest index first on ties
  task automatic pick_top(input bit is_x, input int order, input int n,
                          output gfems_pkg::llr_t vals[13],
                          output logic [7:0] idxs[13]);
    bit              taken [256];
    int              best;
    gfems_pkg::llr_t v;
    gfems_pkg::llr_t vb;
    for (int i = 0; i < 256; i++) taken[i] = 0;
    for (int r = 0; r < n; r++) begin
      best = -1;
      for (int i = 0; i < order; i++) begin
        v = is_x ? x_mem[i] : y_mem[i];
        if (best >= 0) vb = is_x ? x_mem[best] : y_mem[best];
        if (!taken[i] && (best < 0 || v > vb)) best = i;
      end
      taken[best] = 1;
      vals[r] = is_x ? x_mem[best] : y_mem[best];
      idxs[r] = best[7:0];
    end
  endtask

  task automatic predict_z(input int order, input int n);
    gfems_pkg::llr_t      xv [13];
    gfems_pkg::llr_t      yv [13];
    logic [7:0]           xi [13];
    logic [7:0]           yi [13];
    gfems_pkg::llr_t      z [256];
    gfems_pkg::llr_t      t;
    logic [7:0]           k;
    gfems_pkg::out_item_t beat;
    pick_top(1, order, n, xv, xi);
    pick_top(0, order, n, yv, yi);
    for (int i = 0; i < 256; i++) z[i] = 16'sh8000;
    for (int i = 0; i < order; i++) begin
      k = xi[0] ^ i[7:0];
      z[k] = xv[0] + y_mem[i];
    end
    for (int i = 0; i < order; i++) begin
      k = yi[0] ^ i[7:0];
      t = yv[0] + x_mem[i];
      if (t > z[k]) z[k] = t;
    end
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) begin
        k = xi[i] ^ yi[j];
        t = xv[i] + yv[j];
        if (t > z[k]) z[k] = t;
      end
    for (int b = 0; b < order / NLanes; b++) begin
      beat.z_value_0  = z[4*b];
      beat.z_value_1  = z[4*b+1];
      beat.z_value_2  = z[4*b+2];
      beat.z_value_3  = z[4*b+3];
      beat.last_group = (b == order / NLanes - 1);
      z_queue.push_back(beat);
    end
  endtask

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    int                   order;
    int                   base;
    gfems_pkg::out_item_t exp_beat;
    if (!rst_ni) begin
      order_sel    = 1'b1;
      beats_loaded = 0;
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) order_sel = cfg_wdata_i;
      if (in_valid_i && !in_stall_o) begin
        order = order_sel ? LargeOrder : SmallOrder;
        base  = beats_loaded * NLanes;
        x_mem[base]   = clamp_llr(in_data_i.x_value_0);
        x_mem[base+1] = clamp_llr(in_data_i.x_value_1);
        x_mem[base+2] = clamp_llr(in_data_i.x_value_2);
        x_mem[base+3] = clamp_llr(in_data_i.x_value_3);
        y_mem[base]   = clamp_llr(in_data_i.y_value_0);
        y_mem[base+1] = clamp_llr(in_data_i.y_value_1);
        y_mem[base+2] = clamp_llr(in_data_i.y_value_2);
        y_mem[base+3] = clamp_llr(in_data_i.y_value_3);
        beats_loaded++;
        if (beats_loaded >= order / NLanes) begin
          beats_loaded = 0;
          predict_z(order, order_sel ? int'(gfems_pkg::NmLarge)
                                     : int'(gfems_pkg::NmSmall));
        end
      end
      if (out_valid_o && !out_stall_i) begin
        if (z_queue.size() == 0) begin
          $error("z beat with none expected");
          fail_count_o++;
        end else begin
          exp_beat = z_queue.pop_front();
          check_field("z_value_0", exp_beat.z_value_0, out_data_o.z_value_0);
          check_field("z_value_1", exp_beat.z_value_1, out_data_o.z_value_1);
          check_field("z_value_2", exp_beat.z_value_2, out_data_o.z_value_2);
          check_field("z_value_3", exp_beat.z_value_3, out_data_o.z_value_3);
          check_field("last_group", exp_beat.last_group, out_data_o.last_group);
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> verif/gf_ems_two_input_combine_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// gf_ems_two_input_combine_tb : stimulus and verdict
// Drives x/y vectors in GF(64) and GF(256) mode with directed extremes, ties
// and random content under several idle/stall mixes; the checker predicts z.
// ---------------------------------------------------------------------------
`default_nettype none

module gf_ems_two_input_combine_tb;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic                 cfg_wdata_i = 1'b1;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  gfems_pkg::in_item_t  in_data_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  gfems_pkg::out_item_t out_data_o;
  int                   fail_count;
  int                   z_pending;
  int                   send_idle_pct = 0;
  int                   recv_stall_pct = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  gf_ems_two_input_combine dut (.*);

  gf_ems_two_input_combine_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_o,
    .in_data_i, .out_valid_o, .out_stall_i, .out_data_o,
    .fail_count_o(fail_count), .pending_o(z_pending)
  );

  always @(posedge clk_i) out_stall_i <= ($urandom_range(99) < recv_stall_pct);

  // kinds of vector content
  localparam int VecRandom  = 0;
  localparam int VecExtreme = 1;
  localparam int VecTies    = 2;
  localparam int VecNarrow  = 3;

  function automatic gfems_pkg::llr_t make_llr(int kind);
    case (kind)
      VecExtreme: begin
        case ($urandom_range(3))
          0: return 16'sh8000;   // clamps
          1: return 16'sh8001;   // clamps
          2: return 16'sh7fff;
          default: return -16'sd32766;
        endcase
      end
      VecTies:   return gfems_pkg::llr_t'($urandom_range(2) * 100);
      VecNarrow: return gfems_pkg::llr_t'($urandom_range(64) - 32);
      default:   return gfems_pkg::llr_t'($urandom);
    endcase
  endfunction

  // valid stays up after the beat is taken; the next call either offers
  // a new beat or drops valid in the same time step
  task automatic send_beat(int kind);
    gfems_pkg::in_item_t d;
    d = {make_llr(kind), make_llr(kind), make_llr(kind), make_llr(kind),
         make_llr(kind), make_llr(kind), make_llr(kind), make_llr(kind)};
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= d;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_vector(int beats, int kind);
    for (int b = 0; b < beats; b++) send_beat(kind);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (z_pending != 0 || in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain_and_set(logic sel);
    wait_idle();
    repeat (50) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= sel;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int idle_mix [4];
    int stall_mix [4];
    int kind_mix [4];
    idle_mix  = '{0, 76, 0, 34};
    stall_mix = '{0, 0, 76, 34};
    kind_mix  = '{VecExtreme, VecNarrow, VecRandom, VecTies};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // one small-order vector a phase, one large-order vector with ties
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_mix[p];
      recv_stall_pct = stall_mix[p];
      drain_and_set(1'b0);
      send_vector(16, kind_mix[p]);
      if (p == 2) begin
        drain_and_set(1'b1);
        send_vector(64, VecTies);
      end
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    wait_idle();
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire
